// File: sv/keyframe_track_sampler_top_defines.svh
// ----------------------------------------------------------------------------
// Keyframe track sampler assertion macros
// Assertion helpers for the sampler top; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_TRACK_SAMPLER_TOP_DEFINES_SVH
`define KEYFRAME_TRACK_SAMPLER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define KTS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KTS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define KTS_ASSERT(label, clk, rst_n, prop, msg)
`define KTS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: sv/kts_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe track sampler package
// Widths, register indexes, opcodes, sequencer states and divider port types.
// ----------------------------------------------------------------------------
package kts_pkg;
    localparam int MAX_KEYS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 31;

    localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KIND      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP   = 3'd4;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MOD, ST_NORM, ST_SCAN_RD, ST_SCAN, ST_SEG, ST_VEC_RD,
        ST_DIV, ST_MUL, ST_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quo;
        logic [31:0] rem;
    } div_rsp_t;
endpackage

// File: sv/kts_stream_if.sv
// ----------------------------------------------------------------------------
// Keyframe track sampler stream interface
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface kts_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/kts_divider.sv
// ----------------------------------------------------------------------------
// Keyframe track sampler divider
// Radix-2 restoring divider of a 64-bit dividend by a 32-bit divisor.
// ----------------------------------------------------------------------------
module kts_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  kts_pkg::div_req_t req,
    output kts_pkg::div_rsp_t rsp
);
    import kts_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[31:0], quo_reg[63]};
        trial     = shifted - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next  = {req.num, 32'd0};
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg[31:0];
endmodule

// File: sv/keyframe_track_sampler_top.sv
// ----------------------------------------------------------------------------
// Keyframe track sampler
// Stores a keyframe track in memory and samples it by linear interpolation.
// ----------------------------------------------------------------------------
// A load beat writes one keyframe. A sample beat holds the input until its
// result has moved into the output register. In wrap mode the time is first
// reduced by a 64-step shift and subtract divider. The segment is then found
// by a linear scan that reads one key time per cycle from the time memory,
// after a setup step and followed by the end checks. The two key vectors are
// then read. The blend fraction takes a second pass of the same divider. The
// three lerp products follow one after another, and a last step hands the
// result over. Clamp mode, or a clip no longer than the minimum gap, skips the
// first divider pass. A one-key segment, a gap no wider than the minimum gap
// or a time at or before the segment start gives a blend of zero and skips
// the second pass. An empty track skips the scan and the lerp. The finished
// result moves into an output register, so the next beat is taken while it
// waits. A second finished sample waits in its last step until that register
// has been handed on.
module keyframe_track_sampler_top
    import kts_pkg::*;
#(
    parameter int MAX_KEYS  = MAX_KEYS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    kts_stream_if.sink            in_ch,
    kts_stream_if.source          out_ch
);
    import kts_pkg::*;
`include "keyframe_track_sampler_top_defines.svh"

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
    localparam int ONE_Q = 65536;

    // Configuration registers.
    logic [30:0] duration_reg;
    logic [6:0]  key_count_reg;
    logic        wrap_reg, kind_reg;
    logic [15:0] min_gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg  <= '0;
            key_count_reg <= '0;
            wrap_reg      <= 1'b1;
            kind_reg      <= 1'b0;
            min_gap_reg   <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DURATION:  duration_reg  <= cfg_data[30:0];
                REG_KEY_COUNT: key_count_reg <= cfg_data[6:0];
                REG_WRAP:      wrap_reg      <= cfg_data[0];
                REG_KIND:      kind_reg      <= cfg_data[0];
                REG_MIN_GAP:   min_gap_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Key memories: one write port for loads, one registered read port each.
    logic [30:0] time_mem [MAX_KEYS];
    logic [95:0] vec_mem  [MAX_KEYS];
    logic [AW-1:0] t_raddr, v_raddr;
    logic [30:0] t_rdata_reg;
    logic [95:0] v_rdata_reg;
    logic        load_we;
    logic [AW-1:0] load_addr;

    assign load_addr = AW'(in_ch.data.key_index);

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            time_mem[load_addr] <= in_ch.data.key_time;
            vec_mem[load_addr]  <= {in_ch.data.key_x, in_ch.data.key_y, in_ch.data.key_z};
        end
        t_rdata_reg <= time_mem[t_raddr];
        v_rdata_reg <= vec_mem[v_raddr];
    end

    // Sequencer.
    state_t state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [32:0]   t_reg, t_next;          // signed sample time / normalized time
    logic [30:0]   tprev_reg, tprev_next;  // time of key idx-2 during the scan
    logic [30:0]   t0_reg, t0_next;        // time of key 0
    logic          found_reg, found_next;
    logic [AW-1:0] i0_reg, i0_next, i1_reg, i1_next;
    logic [30:0]   ti0_reg, ti0_next, ti1_reg, ti1_next;
    logic [16:0]   blend_reg, blend_next;
    logic [95:0]   a_reg, a_next, b_reg, b_next;
    logic [1:0]    comp_reg, comp_next;
    logic [95:0]   res_reg, res_next;
    logic          sign_reg, sign_next;
    logic          ovalid_reg, ovalid_next;
    logic [95:0]   ores_reg, ores_next;
    logic [5:0]    oseg_reg, oseg_next;
    logic [16:0]   oblend_reg, oblend_next;
    div_req_t      dreq;
    div_rsp_t      drsp;

    kts_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [6:0]  n_sat;
    logic [31:0] mag;
    logic signed [32:0] tn;
    logic signed [32:0] ta, tb;
    logic [31:0] gap;
    logic signed [32:0] numr;
    logic signed [31:0] ca, cb;
    logic signed [32:0] diff;
    logic signed [51:0] prod;
    logic signed [51:0] fl;
    logic [31:0] rcomp;
    logic [63:0] q;

    assign n_sat = (key_count_reg > 7'(MAX_KEYS)) ? 7'(MAX_KEYS) : key_count_reg;

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        t_next      = t_reg;
        tprev_next  = tprev_reg;
        t0_next     = t0_reg;
        found_next  = found_reg;
        i0_next     = i0_reg;
        i1_next     = i1_reg;
        ti0_next    = ti0_reg;
        ti1_next    = ti1_reg;
        blend_next  = blend_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        comp_next   = comp_reg;
        res_next    = res_reg;
        sign_next   = sign_reg;
        ovalid_next = ovalid_reg;
        ores_next   = ores_reg;
        oseg_next   = oseg_reg;
        oblend_next = oblend_reg;
        load_we     = 1'b0;
        dreq        = '0;
        t_raddr     = idx_reg[AW-1:0];
        v_raddr     = i0_reg;
        mag         = t_reg[32] ? 32'(-t_reg) : t_reg[31:0];
        tn          = '0;
        ta          = $signed({2'b0, t_rdata_reg});
        tb          = $signed({2'b0, tprev_reg});
        gap         = 32'(ti1_reg) - 32'(ti0_reg);
        numr        = t_reg - $signed({2'b0, ti0_reg});
        q           = drsp.quo;
        ca          = '0;
        cb          = '0;
        diff        = '0;
        prod        = '0;
        fl          = '0;
        rcomp       = '0;
        if (out_ch.valid && out_ch.ready)
            ovalid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    if (in_ch.data.op == OP_LOAD)
                        load_we = ({1'b0, in_ch.data.key_index} < 7'(MAX_KEYS));
                    else
                    begin
                        n_next    = CW'(n_sat);
                        t_next    = {in_ch.data.sample_time[31], in_ch.data.sample_time};
                        sign_next = in_ch.data.sample_time[31];
                        if ({1'b0, duration_reg} <= {16'd0, min_gap_reg})
                        begin
                            t_next     = '0;
                            state_next = ST_NORM;
                        end
                        else if (wrap_reg)
                        begin
                            dreq.start = 1'b1;
                            dreq.num   = in_ch.data.sample_time[31] ?
                                         -in_ch.data.sample_time : in_ch.data.sample_time;
                            dreq.den   = {1'b0, duration_reg};
                            state_next = ST_MOD;
                        end
                        else
                        begin
                            if (in_ch.data.sample_time[31])
                                t_next = '0;
                            else if (in_ch.data.sample_time > {1'b0, duration_reg})
                                t_next = {2'b0, duration_reg};
                            state_next = ST_NORM;
                        end
                    end
                end
            end
            ST_MOD:
            begin
                // Dividend is |t| << 32; remainder of |t| is rem >> 32 scaled,
                // so take the remainder from the high quotient path instead.
                if (drsp.done)
                begin
                    // quo holds (|t|<<32)/d; recompute |t| mod d via the high bits.
                    rcomp = mag - 32'(q[63:32] * 64'(duration_reg));
                    tn = sign_reg ? -$signed({1'b0, rcomp}) : $signed({1'b0, rcomp});
                    if (tn < 0)
                        tn = tn + $signed({2'b0, duration_reg});
                    t_next     = tn;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                i0_next    = '0;
                i1_next    = '0;
                if (n_reg == '0)
                begin
                    res_next   = kind_reg ? {3{32'(ONE_Q)}} : '0;
                    blend_next = '0;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                // Memory presents key idx on the next cycle.
                idx_next   = idx_reg + CW'(1);
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // t_rdata_reg holds key idx-1.
                if (idx_reg == CW'(1))
                    t0_next = t_rdata_reg;
                else if (!found_reg && t_reg >= tb && t_reg < ta)
                begin
                    found_next = 1'b1;
                    i0_next    = AW'(idx_reg - CW'(2));
                    i1_next    = AW'(idx_reg - CW'(1));
                    ti0_next   = tprev_reg;
                    ti1_next   = t_rdata_reg;
                end
                tprev_next = t_rdata_reg;
                if (idx_reg == n_reg)
                    state_next = ST_SEG;
                else
                    idx_next = idx_reg + CW'(1);
            end
            ST_SEG:
            begin
                // tprev_reg holds the last key time.
                if (t_reg < $signed({2'b0, t0_reg}))
                begin
                    i0_next = '0;
                    i1_next = '0;
                end
                else if (t_reg >= $signed({2'b0, tprev_reg}))
                begin
                    i0_next = AW'(n_reg - CW'(1));
                    i1_next = AW'(n_reg - CW'(1));
                end
                state_next = ST_VEC_RD;
                blend_next = '0;
            end
            ST_VEC_RD:
            begin
                // The read of a is issued first, then the read of b.
                if (comp_reg == 2'd0)
                begin
                    comp_next = 2'd1;
                end
                else if (comp_reg == 2'd1)
                begin
                    v_raddr   = i1_reg;
                    a_next    = v_rdata_reg;
                    comp_next = 2'd2;
                end
                else
                begin
                    b_next    = v_rdata_reg;
                    comp_next = 2'd0;
                    if (i0_reg != i1_reg && gap > {16'd0, min_gap_reg} && numr > 0)
                    begin
                        dreq.start = 1'b1;
                        dreq.num   = numr[31:0];
                        dreq.den   = gap;
                        state_next = ST_DIV;
                    end
                    else
                        state_next = ST_MUL;
                end
            end
            ST_DIV:
            begin
                // quo = (num << 32) / gap; shift back to FRAC_BITS.
                if (drsp.done)
                begin
                    if ((q >> (32 - FRAC_BITS)) > ONE)
                        blend_next = 17'(ONE);
                    else
                        blend_next = 17'(q >> (32 - FRAC_BITS));
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                ca   = $signed(a_reg[95:64]);
                cb   = $signed(b_reg[95:64]);
                diff = 33'(cb) - 33'(ca);
                prod = 52'(diff) * $signed({35'd0, blend_reg});
                fl   = prod >>> FRAC_BITS;
                res_next = {res_reg[63:0], 32'(52'(ca) + fl)};
                a_next   = {a_reg[63:0], 32'd0};
                b_next   = {b_reg[63:0], 32'd0};
                comp_next = comp_reg + 2'd1;
                if (comp_reg == 2'd2)
                begin
                    comp_next  = 2'd0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // The output register takes the result once it is free, or
                // in the cycle its previous beat is handed on.
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    ores_next   = res_reg;
                    oseg_next   = 6'(i0_reg);
                    oblend_next = blend_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            comp_reg   <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            comp_reg   <= comp_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        idx_reg    <= idx_next;
        t_reg      <= t_next;
        tprev_reg  <= tprev_next;
        t0_reg     <= t0_next;
        i0_reg     <= i0_next;
        i1_reg     <= i1_next;
        ti0_reg    <= ti0_next;
        ti1_reg    <= ti1_next;
        blend_reg  <= blend_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        res_reg    <= res_next;
        sign_reg   <= sign_next;
        ores_reg   <= ores_next;
        oseg_reg   <= oseg_next;
        oblend_reg <= oblend_next;
    end

    assign in_ch.ready            = (state_reg == ST_IDLE);
    assign out_ch.valid           = ovalid_reg;
    assign out_ch.data.out_x      = ores_reg[95:64];
    assign out_ch.data.out_y      = ores_reg[63:32];
    assign out_ch.data.out_z      = ores_reg[31:0];
    assign out_ch.data.segment_start = oseg_reg;
    assign out_ch.data.blend      = oblend_reg;

    `KTS_ASSERT(a_blend_max, clk, rst_n, (out_ch.valid |-> out_ch.data.blend <= 17'(ONE)), "blend above one")
    `KTS_ASSERT(a_div_idle, clk, rst_n, (in_ch.ready |-> !drsp.busy), "divider busy while idle")
    `KTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped")
    `KTS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_ch.valid && !out_ch.ready, $stable(out_ch.data), "result changed while waiting")
endmodule

// File: tb/kts_tb_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe track sampler test types
// Payload layouts of the input and result channels as seen by the bench.
// ----------------------------------------------------------------------------
package kts_tb_pkg;
    typedef struct packed {
        logic               op;
        logic [5:0]         key_index;
        logic [30:0]        key_time;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
        logic signed [31:0] sample_time;
    } kts_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [5:0]         segment_start;
        logic [16:0]        blend;
    } kts_out_t;
endpackage

// File: tb/kts_checker.sv
// ----------------------------------------------------------------------------
// Keyframe track sampler checker
// Mirrors the register writes and keyframe loads, predicts every sample beat
// and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module kts_checker
    import kts_pkg::*;
    import kts_tb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    kts_stream_if                 mon_in,
    kts_stream_if                 mon_out,
    output int                    pending,
    output int                    fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NKEYS = 64;
    localparam int  FRAC  = 16;

    longint   key_t_mem [NKEYS];
    longint   key_v_mem [NKEYS][3];
    longint   duration_q, count_q, gap_q;
    logic     wrap_q, kind_q;
    kts_out_t sample_queue[$];

    function automatic kts_out_t interpolate_sample(logic signed [31:0] st);
        kts_out_t res;
        longint   d, t, n, blend, gap, num, a, b, r;
        int       i0, i1;
        d = duration_q;
        i0 = 0;
        i1 = 0;
        blend = 0;
        if (d <= gap_q) t = 0;
        else if (wrap_q)
        begin
            t = longint'(st) % d;
            if (t < 0) t += d;
        end
        else if (st < 0) t = 0;
        else if (longint'(st) > d) t = d;
        else t = st;
        n = (count_q > NKEYS) ? NKEYS : count_q;
        if (n == 0)
        begin
            r = kind_q ? 65536 : 0;
            res.out_x = r[31:0];
            res.out_y = r[31:0];
            res.out_z = r[31:0];
            res.segment_start = '0;
            res.blend = '0;
            return res;
        end
        if (n > 1)
        begin
            for (int i = 0; i + 1 < n; i++)
            begin
                if (t >= key_t_mem[i] && t < key_t_mem[i+1])
                begin
                    i0 = i;
                    i1 = i + 1;
                    break;
                end
            end
            if (t < key_t_mem[0])
            begin
                i0 = 0;
                i1 = 0;
            end
            else if (t >= key_t_mem[n-1])
            begin
                i0 = int'(n - 1);
                i1 = int'(n - 1);
            end
            if (i0 != i1)
            begin
                gap = key_t_mem[i1] - key_t_mem[i0];
                if (gap > gap_q)
                begin
                    num = t - key_t_mem[i0];
                    if (num > 0)
                    begin
                        blend = (num << FRAC) / gap;
                        if (blend > (64'sd1 << FRAC)) blend = 64'sd1 << FRAC;
                    end
                end
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            a = key_v_mem[i0][c];
            b = key_v_mem[i1][c];
            r = a + (((b - a) * blend) >>> FRAC);
            if (c == 0) res.out_x = r[31:0];
            else if (c == 1) res.out_y = r[31:0];
            else res.out_z = r[31:0];
        end
        res.segment_start = i0[5:0];
        res.blend = blend[16:0];
        return res;
    endfunction

    assign pending = sample_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        kts_out_t exp_r;
        kts_out_t got;
        kts_in_t  beat;
        if (!rst_n)
        begin
            duration_q <= 0;
            count_q    <= 0;
            wrap_q     <= 1'b1;
            kind_q     <= 1'b0;
            gap_q      <= 1;
            fail_count <= 0;
            sample_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DURATION:  duration_q <= longint'(cfg_data[30:0]);
                    REG_KEY_COUNT: count_q    <= longint'(cfg_data[6:0]);
                    REG_WRAP:      wrap_q     <= cfg_data[0];
                    REG_KIND:      kind_q     <= cfg_data[0];
                    REG_MIN_GAP:   gap_q      <= longint'(cfg_data[15:0]);
                    default: ;
                endcase
            end
            // Results are checked before new beats are predicted; a result can
            // never belong to a beat accepted at the same edge.
            if (mon_out.valid && mon_out.ready)
            begin
                got = mon_out.data;
                if (sample_queue.size() == 0)
                begin
                    $display("%t: unexpected result beat %p", $realtime, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = sample_queue.pop_front();
                    if (got.out_x !== exp_r.out_x || got.out_y !== exp_r.out_y ||
                        got.out_z !== exp_r.out_z ||
                        got.segment_start !== exp_r.segment_start ||
                        got.blend !== exp_r.blend)
                    begin
                        $display("%t: result mismatch expected x=%0d y=%0d z=%0d seg=%0d blend=%0d",
                                 $realtime, exp_r.out_x, exp_r.out_y, exp_r.out_z,
                                 exp_r.segment_start, exp_r.blend);
                        $display("%t:                  actual x=%0d y=%0d z=%0d seg=%0d blend=%0d",
                                 $realtime, got.out_x, got.out_y, got.out_z,
                                 got.segment_start, got.blend);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (mon_in.valid && mon_in.ready)
            begin
                beat = mon_in.data;
                if (beat.op == OP_LOAD)
                begin
                    key_t_mem[beat.key_index]    = longint'(beat.key_time);
                    key_v_mem[beat.key_index][0] = longint'(beat.key_x);
                    key_v_mem[beat.key_index][1] = longint'(beat.key_y);
                    key_v_mem[beat.key_index][2] = longint'(beat.key_z);
                end
                else
                    sample_queue.insert(sample_queue.size(),
                                        interpolate_sample(beat.sample_time));
            end
        end
    end
endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Keyframe track sampler testbench
// Loads keyframe tracks, reprograms the sampler between phases and samples
// it with directed and random times under varying backpressure.
// ----------------------------------------------------------------------------
module testbench;
    import kts_pkg::*;
    import kts_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Watchdog limit, far above the time the slowest sample takes.
    localparam int     CYCLE_LIMIT = 2000000;
    // Drain time after the last result before the block counts as idle.
    localparam int     SETTLE      = 250;
    localparam longint MAX_T       = 64'h7FFF_FFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    fail_count;
    int                    cycles;

    // Idling knobs for the current phase, in percent.
    int     idle_pct;
    int     stall_pct;
    bit     hold_req;
    int     beats_sent;
    // Bench copy of the loaded key times, used to aim samples at them.
    longint key_times_tb [64];
    bit     slot_loaded  [64];
    longint duration_tb;

    kts_stream_if #(.T(kts_in_t))  in_ch ();
    kts_stream_if #(.T(kts_out_t)) out_ch ();

    keyframe_track_sampler_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    kts_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mon_in     (in_ch),
        .mon_out    (out_ch),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side. Ready follows the stall percentage of the phase. When a
    // long hold is requested the sink keeps ready low, which lets the sampler
    // fill its output register and refuse input.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Sends one beat. The task starts and ends right after a rising edge.
    // Ready is sampled at the falling edge, where it has settled for the
    // coming edge, so the handshake never depends on event order.
    task automatic send_beat(kts_in_t beat);
        bit hs;
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= beat;
        do
        begin
            @(negedge clk);
            hs = in_ch.ready;
            @(posedge clk);
        end
        while (!hs);
        beats_sent++;
    endtask

    task automatic load_key(int slot, longint t, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z);
        kts_in_t b;
        b = '0;
        b.op        = OP_LOAD;
        b.key_index = slot[5:0];
        b.key_time  = t[30:0];
        b.key_x     = x;
        b.key_y     = y;
        b.key_z     = z;
        key_times_tb[slot] = t & MAX_T;
        slot_loaded[slot]  = 1'b1;
        send_beat(b);
    endtask

    task automatic sample_at(logic [31:0] st);
        kts_in_t b;
        b = '0;
        b.op          = OP_SAMPLE;
        b.key_index   = 6'($urandom);
        b.key_time    = 31'($urandom);
        b.key_x       = $urandom;
        b.key_y       = $urandom;
        b.key_z       = $urandom;
        b.sample_time = st;
        send_beat(b);
    endtask

    // Waits until every expected result is back, then lets the block drain.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes all five registers back to back; the enable drops only once.
    task automatic program_track(longint dur, int cnt, bit wrap, bit kind, int gap);
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        idx[0] = REG_DURATION;  val[0] = dur[30:0];
        idx[1] = REG_KEY_COUNT; val[1] = CFG_DATA_W'(cnt);
        idx[2] = REG_WRAP;      val[2] = CFG_DATA_W'(wrap);
        idx[3] = REG_KIND;      val[3] = CFG_DATA_W'(kind);
        idx[4] = REG_MIN_GAP;   val[4] = CFG_DATA_W'(gap);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        duration_tb = dur & MAX_T;
    endtask

    // Picks a sample time: anywhere, inside the clip, on or next to a key or the
    // clip end, negative down to minus the clip length, or at the field extremes.
    function automatic logic [31:0] pick_time(int nkeys);
        longint kt;
        kt = key_times_tb[$urandom_range(nkeys > 0 ? nkeys - 1 : 0)];
        case ($urandom_range(7))
            0: return $urandom;
            1, 2: return $urandom_range(duration_tb[31:0]);
            3: return kt[31:0];
            4: return kt[31:0] + $urandom_range(3) - 1;
            5: return -$urandom_range(duration_tb[31:0]) - $urandom_range(3);
            6: return duration_tb[31:0] + $urandom_range(2) - 1;
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // One random phase: a fresh track of keys, a new register
    // setting and a run of samples with an occasional reload in between.
    task automatic random_phase(int phase_no);
        int     nkeys, cnt, gap, nsamp;
        longint t, dur;
        bit     full;
        full  = (phase_no % 7 == 3);
        nkeys = full ? 64 : $urandom_range(2, 9);
        gap   = ($urandom_range(3) == 0) ? (($urandom_range(1) == 1) ? 65535 : 0)
                                         : $urandom_range(0, 40);
        t     = $urandom_range(3) == 0 ? 0 : $urandom_range(0, 200000);
        for (int k = 0; k < nkeys; k++)
        begin
            // Mostly ascending keys with some zero and sub-gap spacings; now
            // and then a key out of order.
            if ($urandom_range(19) == 0) t = $urandom & MAX_T;
            load_key(k, t, $urandom, $urandom, $urandom);
            case ($urandom_range(5))
                0: t += 0;
                1: t += $urandom_range(0, gap + 1);
                default: t += $urandom_range(1, 1 << 20);
            endcase
            if (t > MAX_T) t = MAX_T;
        end
        // Load traffic leaves no result behind, so only the drain applies.
        wait_idle();
        case ($urandom_range(7))
            0: dur = 0;
            1: dur = MAX_T;
            2: dur = $urandom_range(0, 65535);
            default: dur = key_times_tb[nkeys-1] + $urandom_range(0, 300000);
        endcase
        if (dur > MAX_T) dur = MAX_T;
        cnt = nkeys;
        if (full)
            cnt = $urandom_range(1) ? 127 : $urandom_range(64, 127);
        else if ($urandom_range(5) == 0)
            cnt = $urandom_range(0, nkeys);
        program_track(dur, cnt, 1'($urandom_range(1)), 1'($urandom_range(1)), gap);
        nsamp = $urandom_range(12, 30);
        for (int s = 0; s < nsamp; s++)
        begin
            if ($urandom_range(15) == 0)
            begin
                int slot;
                slot = $urandom_range(nkeys - 1);
                load_key(slot, key_times_tb[slot], $urandom, $urandom, $urandom);
            end
            sample_at(pick_time(nkeys));
        end
        wait_idle();
    endtask

    initial
    begin
        int phase_no;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_req    = 1'b0;
        beats_sent  = 0;
        duration_tb = 0;
        foreach (key_times_tb[i]) key_times_tb[i] = 0;
        foreach (slot_loaded[i]) slot_loaded[i] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An empty track gives zero for a position track and
        // one for a scale track, whatever the time.
        sample_at(32'h1234_5678);
        wait_idle();
        program_track(0, 0, 1'b1, 1'b1, 1);
        sample_at(32'h8000_0000);
        // Four keys with a zero-length segment in the middle, plus the top
        // slot with the largest time and the extremes of every component.
        load_key(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        load_key(1, 100000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        load_key(2, 100000, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
        load_key(3, 300000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        load_key(63, MAX_T, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0);
        wait_idle();
        // A single key returns that key unchanged.
        program_track(400000, 1, 1'b1, 1'b0, 1);
        sample_at(32'd250000);
        wait_idle();
        // Wrapped time: negative times, the field extremes, exact key times
        // and the middle of a segment.
        program_track(400000, 4, 1'b1, 1'b0, 1);
        sample_at(32'hFFFF_FFFF);
        sample_at(32'h8000_0000);
        sample_at(32'h7FFF_FFFF);
        sample_at(32'd100000);
        sample_at(32'd50000);
        sample_at(32'd350000);
        wait_idle();
        // Clamped time, the widest minimum gap, and a clip no longer than the
        // minimum gap, which forces time zero.
        program_track(400000, 4, 1'b0, 1'b1, 65535);
        sample_at(32'hFFFF_0000);
        sample_at(32'd500000);
        sample_at(32'd40000);
        sample_at(32'd150000);
        wait_idle();
        program_track(MAX_T, 4, 1'b0, 1'b0, 0);
        sample_at(32'h7FFF_FFFF);
        sample_at(32'd200000);
        wait_idle();
        program_track(65535, 4, 1'b1, 1'b0, 65535);
        sample_at(32'd123456);
        wait_idle();

        // Random part, cycling through the idling mixes.
        phase_no = 0;
        while (beats_sent < 550)
        begin
            case (phase_no % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            // Once, the sink holds off for a long stretch while the source
            // keeps offering beats.
            if (phase_no == 2) hold_req = 1'b1;
            random_phase(phase_no);
            phase_no++;
        end

        in_ch.valid <= 1'b0;
        wait_idle();
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
